// ----- hw/rtl/crts_pkg.sv -----
package crts_pkg;

   localparam logic [1:0] CMD_CLEAR    = 2'd0;
   localparam logic [1:0] CMD_TRAIN    = 2'd1;
   localparam logic [1:0] CMD_CLASSIFY = 2'd2;
   localparam logic [1:0] CMD_UNUSED   = 2'd3;

   localparam int RATIO_W  = 16;
   localparam int MARGIN_W = 9;
   localparam logic [RATIO_W-1:0] RATIO_MAX = 16'hFFFF;

   // Work item handed from the front part to the back part.
   typedef struct packed {
      logic                clear;
      logic                train;
      logic                classify;
      logic [7:0]          gray;
      logic [RATIO_W-1:0]  b2g;
      logic [RATIO_W-1:0]  g2r;
   } work_type;

endpackage

// ----- hw/rtl/color_ratio_table_segmenter.sv -----
// Color-ratio segmenter with a per-gray-level bound table. Each pixel's time
// in the front part is set by the two bit-serial ratio dividers; the back
// part handles each item as table read, update/compare, write, plus the
// response transfer, and a two-entry queue between them lets both parts run
// at once. A clear skips the dividers in the front part, passes through the
// queue in order with the pixels and yields no response; the bound table
// holds per-entry valid flags so no clearing pass is needed.
module color_ratio_table_segmenter #(
   parameter int GRAY_LEVELS     = 256,
   parameter int RATIO_FRAC_BITS = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [1:0]        req_cmd,
   input  logic [7:0]        req_blue,
   input  logic [7:0]        req_green,
   input  logic [7:0]        req_red,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              rsp_in_region,
   input  logic              csr_we,
   input  logic signed [8:0] csr_wdata
);
   import crts_pkg::*;

   logic signed [8:0] margin_ff;
   logic     f_valid, f_ready, q_valid, q_ready;
   work_type f_data, q_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         margin_ff <= '0;
      end else if (csr_we) begin
         margin_ff <= csr_wdata;
      end
   end

   crts_front #(.RATIO_FRAC_BITS(RATIO_FRAC_BITS)) u_front (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
      .req_cmd(req_cmd), .req_blue(req_blue), .req_green(req_green),
      .req_red(req_red), .wk_valid(f_valid),
      .wk_ready(f_ready), .wk_data(f_data));

   crts_queue u_queue (
      .clock(clock), .reset(reset), .in_valid(f_valid), .in_ready(f_ready),
      .in_data(f_data), .out_valid(q_valid), .out_ready(q_ready),
      .out_data(q_data));

   crts_back #(.GRAY_LEVELS(GRAY_LEVELS), .RATIO_FRAC_BITS(RATIO_FRAC_BITS)) u_back (
      .clock(clock), .reset(reset),
      .margin(margin_ff), .wk_valid(q_valid), .wk_ready(q_ready),
      .wk_data(q_data), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_in_region(rsp_in_region));
endmodule

// ----- hw/rtl/crts_ram.sv -----
module crts_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ----- hw/rtl/crts_divider.sv -----
// Restoring divider, one quotient bit per cycle; numerator is an 8-bit value
// shifted left by FRAC bits, quotient saturated to 16 bits.
module crts_divider #(
   parameter int FRAC = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [7:0]  num,
   input  logic [7:0]  den,
   output logic        done,
   output logic [15:0] quot
);
   import crts_pkg::*;

   localparam int NW = 8 + FRAC;
   localparam int CW = $clog2(NW + 1);

   logic [NW-1:0] num_ff, num_in;
   logic [NW-1:0] q_ff, q_in;
   logic [8:0]    rem_ff, rem_in;
   logic [7:0]    den_ff, den_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [9:0]    trial;

   always_comb begin
      num_in  = num_ff;
      q_in    = q_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = '0;
      if (start) begin
         num_in  = {num, {FRAC{1'b0}}};
         den_in  = den;
         rem_in  = '0;
         q_in    = '0;
         cnt_in  = CW'(NW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         trial  = {rem_ff, num_ff[NW-1]} - {2'b0, den_ff};
         num_in = num_ff << 1;
         if (!trial[9]) begin
            rem_in = trial[8:0];
            q_in   = {q_ff[NW-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[7:0], num_ff[NW-1]};
            q_in   = {q_ff[NW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      q_ff   <= q_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   always_comb begin
      if (den_ff == 8'd0) begin
         quot = RATIO_MAX;
      end else if (NW > 16 && (q_ff >> 16) != '0) begin
         quot = RATIO_MAX;
      end else begin
         quot = 16'(q_ff);
      end
   end
endmodule

// ----- hw/rtl/crts_front.sv -----
// Front: pixel -> gray level, ratios, work item; clear skips math; unused dropped.
module crts_front #(
   parameter int RATIO_FRAC_BITS = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_cmd,
   input  logic [7:0]         req_blue,
   input  logic [7:0]         req_green,
   input  logic [7:0]         req_red,
   output logic               wk_valid,
   input  logic               wk_ready,
   output crts_pkg::work_type wk_data
);
   import crts_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_MUL  = 2'd1;
   localparam logic [1:0] ST_DIV  = 2'd2;
   localparam logic [1:0] ST_OUT  = 2'd3;

   logic [1:0]  st_ff, st_in;
   logic [1:0]  cmd_ff;
   logic [7:0]  b_ff, g_ff, r_ff;
   logic [24:0] sum_ff;
   logic [7:0]  gray_ff;
   logic [15:0] b2g_ff, g2r_ff;
   logic        d1_got_ff, d2_got_ff;
   logic        start;
   logic        d1_done, d2_done;
   logic [15:0] d1_q, d2_q;
   logic        accept;

   assign req_ready = (st_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign start = (st_ff == ST_MUL);

   crts_divider #(.FRAC(RATIO_FRAC_BITS)) u_div_bg (
      .clock(clock), .reset(reset), .start(start), .num(b_ff), .den(g_ff),
      .done(d1_done), .quot(d1_q));
   crts_divider #(.FRAC(RATIO_FRAC_BITS)) u_div_gr (
      .clock(clock), .reset(reset), .start(start), .num(g_ff), .den(r_ff),
      .done(d2_done), .quot(d2_q));

   always_comb begin
      st_in = st_ff;
      case (st_ff)
         ST_IDLE: begin
            // clear goes straight to the queue so it stays in order with pixels
            if (accept && req_cmd == CMD_CLEAR) begin
               st_in = ST_OUT;
            end else if (accept && (req_cmd == CMD_TRAIN || req_cmd == CMD_CLASSIFY)) begin
               st_in = ST_MUL;
            end
         end
         ST_MUL: st_in = ST_DIV;
         ST_DIV: begin
            if ((d1_got_ff || d1_done) && (d2_got_ff || d2_done)) begin
               st_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (wk_ready) begin
               st_in = ST_IDLE;
            end
         end
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff     <= ST_IDLE;
         d1_got_ff <= 1'b0;
         d2_got_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         if (start) begin
            d1_got_ff <= 1'b0;
            d2_got_ff <= 1'b0;
         end else begin
            if (d1_done) d1_got_ff <= 1'b1;
            if (d2_done) d2_got_ff <= 1'b1;
         end
      end
      if (accept) begin
         cmd_ff <= req_cmd;
         b_ff   <= req_blue;
         g_ff   <= req_green;
         r_ff   <= req_red;
      end
      if (start) begin
         sum_ff <= 25'(25'd1868 * b_ff) + 25'(25'd9617 * g_ff)
                 + 25'(25'd4899 * r_ff) + 25'd8192;
      end
      gray_ff <= sum_ff[21:14];
      if (d1_done) b2g_ff <= d1_q;
      if (d2_done) g2r_ff <= d2_q;
   end

   assign wk_valid = (st_ff == ST_OUT);
   always_comb begin
      wk_data.clear    = (cmd_ff == CMD_CLEAR);
      wk_data.train    = (cmd_ff == CMD_TRAIN);
      wk_data.classify = (cmd_ff == CMD_CLASSIFY);
      wk_data.gray     = gray_ff;
      wk_data.b2g      = b2g_ff;
      wk_data.g2r      = g2r_ff;
   end
endmodule

// ----- hw/rtl/crts_queue.sv -----
// Two-entry queue between front and back.
module crts_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  crts_pkg::work_type in_data,
   output logic               out_valid,
   input  logic               out_ready,
   output crts_pkg::work_type out_data
);
   import crts_pkg::*;

   work_type   slot_ff [2];
   logic       wp_ff, rp_ff;
   logic [1:0] cnt_ff;
   logic       push, pop;

   assign in_ready  = (cnt_ff != 2'd2);
   assign out_valid = (cnt_ff != 2'd0);
   assign out_data  = slot_ff[rp_ff];
   assign push = in_valid && in_ready;
   assign pop  = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) wp_ff <= ~wp_ff;
         if (pop)  rp_ff <= ~rp_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
      if (push) slot_ff[wp_ff] <= in_data;
   end
endmodule

// ----- hw/rtl/crts_back.sv -----
// Back part: read entry, update or compare, write back / emit result; a clear drops all entry valid flags.
module crts_back #(
   parameter int GRAY_LEVELS     = 256,
   parameter int RATIO_FRAC_BITS = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic signed [8:0]  margin,
   input  logic               wk_valid,
   output logic               wk_ready,
   input  crts_pkg::work_type wk_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_in_region
);
   import crts_pkg::*;

   localparam int AW = (GRAY_LEVELS > 1) ? $clog2(GRAY_LEVELS) : 1;
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_READ = 2'd1;
   localparam logic [1:0] ST_EXEC = 2'd2;
   localparam logic [1:0] ST_RESP = 2'd3;

   logic [1:0]        st_ff, st_in;
   work_type          wk_ff;
   logic [AW-1:0]     idx_ff;
   logic [GRAY_LEVELS-1:0] valid_ff;
   logic [63:0]       rd_data, wr_data;
   logic              wr_en;
   logic              hit_ff, res_ff;
   logic [15:0]       bmin, bmax, gmin, gmax;
   logic signed [21:0] m, v1, v2, lo1, hi1, lo2, hi2;
   logic [15:0]       nbmin, nbmax, ngmin, ngmax;
   logic [16+AW-1:0]  prod;
   logic              ev;

   assign prod = (16+AW)'(wk_data.gray) * (16+AW)'(GRAY_LEVELS);

   crts_ram #(.WIDTH(64), .DEPTH(GRAY_LEVELS)) u_table (
      .clock(clock), .wr_en(wr_en), .wr_addr(idx_ff), .wr_data(wr_data),
      .rd_addr(idx_ff), .rd_data(rd_data));

   assign bmin = rd_data[15:0];
   assign bmax = rd_data[31:16];
   assign gmin = rd_data[47:32];
   assign gmax = rd_data[63:48];
   assign ev   = valid_ff[idx_ff];

   always_comb begin
      if (RATIO_FRAC_BITS >= 8) begin
         m = 22'(margin) <<< (RATIO_FRAC_BITS - 8);
      end else if (margin < 0) begin
         m = -((-22'(margin)) >>> (8 - RATIO_FRAC_BITS));
      end else begin
         m = 22'(margin) >>> (8 - RATIO_FRAC_BITS);
      end
      v1  = $signed({6'b0, wk_ff.b2g});
      v2  = $signed({6'b0, wk_ff.g2r});
      lo1 = $signed({6'b0, bmin}) - m;
      hi1 = $signed({6'b0, bmax}) + m;
      lo2 = $signed({6'b0, gmin}) - m;
      hi2 = $signed({6'b0, gmax}) + m;
      nbmin = wk_ff.b2g; nbmax = wk_ff.b2g;
      ngmin = wk_ff.g2r; ngmax = wk_ff.g2r;
      if (ev) begin
         if (bmin < nbmin) nbmin = bmin;
         if (bmax > nbmax) nbmax = bmax;
         if (gmin < ngmin) ngmin = gmin;
         if (gmax > ngmax) ngmax = gmax;
      end
      wr_data = {ngmax, ngmin, nbmax, nbmin};
      wr_en   = (st_ff == ST_EXEC) && wk_ff.train;
   end

   always_comb begin
      st_in = st_ff;
      case (st_ff)
         ST_IDLE: if (wk_valid) st_in = ST_READ;
         ST_READ: st_in = ST_EXEC;
         ST_EXEC: st_in = wk_ff.classify ? ST_RESP : ST_IDLE;
         ST_RESP: if (rsp_ready) st_in = ST_IDLE;
         default: st_in = ST_IDLE;
      endcase
   end

   assign wk_ready = (st_ff == ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff    <= ST_IDLE;
         valid_ff <= '0;
      end else begin
         st_ff <= st_in;
         if ((st_ff == ST_EXEC) && wk_ff.clear) begin
            valid_ff <= '0;
         end else if (wr_en) begin
            valid_ff[idx_ff] <= 1'b1;
         end
      end
      if (wk_valid && wk_ready) begin
         wk_ff  <= wk_data;
         idx_ff <= AW'(prod >> 8);
      end
      if (st_ff == ST_EXEC) begin
         res_ff <= ev && v1 >= lo1 && v1 <= hi1 && v2 >= lo2 && v2 <= hi2;
      end
      hit_ff <= (st_in == ST_RESP);
   end

   assign rsp_valid     = (st_ff == ST_RESP);
   assign rsp_in_region = res_ff && hit_ff;
endmodule

// ----- hw/rtl/crts_checker.sv -----
module crts_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic [1:0] req_cmd,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_in_region
);
   import crts_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_in_region))
      else $error("response dropped or changed while stalled");

   a_no_rsp_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response right after reset");

   a_busy_after_cmd: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_cmd != CMD_UNUSED
      |=> !req_ready)
      else $error("front accepted while an item was in progress");

   a_unused_no_stall: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_cmd == CMD_UNUSED |=> req_ready)
      else $error("unused command stalled the front");
endmodule

bind color_ratio_table_segmenter crts_checker u_crts_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
   .req_cmd(req_cmd), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
   .rsp_in_region(rsp_in_region));

// ----- dv/color_ratio_table_segmenter_test.sv -----
module color_ratio_table_segmenter_test;
   timeunit 1ns;
   timeprecision 1ps;
   import crts_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES   = 64;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic [1:0]        req_cmd = CMD_CLEAR;
   logic [7:0]        req_blue = '0;
   logic [7:0]        req_green = '0;
   logic [7:0]        req_red = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic              rsp_in_region;
   logic              csr_we = 1'b0;
   logic signed [8:0] csr_wdata = '0;

   color_ratio_table_segmenter dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_cmd(req_cmd),
      .req_blue(req_blue), .req_green(req_green), .req_red(req_red),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_in_region(rsp_in_region),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // predictor state
   logic [RATIO_W-1:0] b2g_lo [256];
   logic [RATIO_W-1:0] b2g_hi [256];
   logic [RATIO_W-1:0] g2r_lo [256];
   logic [RATIO_W-1:0] g2r_hi [256];
   bit                 level_trained [256];
   int                 margin_val;

   bit  region_expected [$];
   int  error_count;
   int  idle_cycles;
   int  transfers_in, hits_seen, misses_seen;

   typedef struct {
      logic [1:0] cmd;
      logic [7:0] b, g, r;
      int         want;   // -1: take predictor
   } pixel_row;

   function automatic logic [RATIO_W-1:0] fixed_ratio(logic [7:0] num, logic [7:0] den);
      int unsigned q;
      if (den == 0) return RATIO_MAX;
      q = (int'(num) << 8) / den;
      return (q > 32'hFFFF) ? RATIO_MAX : q[15:0];
   endfunction

   function automatic int gray_of(logic [7:0] b, logic [7:0] g, logic [7:0] r);
      return (1868 * b + 9617 * g + 4899 * r + 8192) >> 14;
   endfunction

   function automatic bit within_margin(logic [15:0] v, logic [15:0] lo, logic [15:0] hi);
      return int'(v) >= int'(lo) - margin_val && int'(v) <= int'(hi) + margin_val;
   endfunction

   // updates table; returns 1 if a classify result is due
   function automatic bit apply_pixel(logic [1:0] cmd, logic [7:0] b, logic [7:0] g,
                                      logic [7:0] r, output bit hit);
      int lvl;
      logic [15:0] bg, gr;
      hit = 0;
      if (cmd == CMD_CLEAR) begin
         foreach (level_trained[i]) level_trained[i] = 0;
         return 0;
      end
      if (cmd != CMD_TRAIN && cmd != CMD_CLASSIFY) return 0;
      lvl = gray_of(b, g, r);
      bg = fixed_ratio(b, g);
      gr = fixed_ratio(g, r);
      if (cmd == CMD_TRAIN) begin
         if (!level_trained[lvl]) begin
            b2g_lo[lvl] = bg; b2g_hi[lvl] = bg; g2r_lo[lvl] = gr; g2r_hi[lvl] = gr;
         end else begin
            if (bg < b2g_lo[lvl]) b2g_lo[lvl] = bg;
            if (bg > b2g_hi[lvl]) b2g_hi[lvl] = bg;
            if (gr < g2r_lo[lvl]) g2r_lo[lvl] = gr;
            if (gr > g2r_hi[lvl]) g2r_hi[lvl] = gr;
         end
         level_trained[lvl] = 1;
         return 0;
      end
      hit = level_trained[lvl] && within_margin(bg, b2g_lo[lvl], b2g_hi[lvl])
            && within_margin(gr, g2r_lo[lvl], g2r_hi[lvl]);
      return 1;
   endfunction

   task automatic report_mismatch(string what);
      $display("MISMATCH @%0t: %s", $time, what);
      error_count++;
   endtask

   // valid stays high after the transfer; the caller drops it before any gap
   task automatic send_pixel(pixel_row row);
      bit due, hit;
      req_valid <= 1'b1;
      req_cmd   <= row.cmd;
      req_blue  <= row.b;
      req_green <= row.g;
      req_red   <= row.r;
      do @(posedge clock); while (!req_ready);
      transfers_in++;
      due = apply_pixel(row.cmd, row.b, row.g, row.r, hit);
      if (due) begin
         if (row.want >= 0 && row.want != int'(hit))
            report_mismatch($sformatf("directed expectation %0d disagrees with table",
                                      row.want));
         region_expected.insert(region_expected.size(),
                                row.want >= 0 ? bit'(row.want) : hit);
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (region_expected.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_margin(logic signed [8:0] m);
      wait_drained();
      csr_we <= 1'b1;
      csr_wdata <= m;
      @(posedge clock);
      csr_we <= 1'b0;
      margin_val = int'(m);
   endtask

   // response side: own stall pattern
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (region_expected.size() == 0) begin
               report_mismatch("response with none expected");
            end else begin
               if (rsp_in_region !== region_expected[0])
                  report_mismatch($sformatf("in_region got %b want %b",
                                            rsp_in_region, region_expected[0]));
               if (region_expected[0]) hits_seen++; else misses_seen++;
               void'(region_expected.pop_front());
            end
         end
         rsp_ready <= ($urandom_range(0, 7) != 0) || (($time / 4000) % 3 == 0);
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Watchdog expired with %0d results pending", region_expected.size());
         $display("Test completed with failures");
         $finish;
      end
   end

   pixel_row directed [] = '{
      '{CMD_CLASSIFY, 8'd10,  8'd20,  8'd30,  0},  // untrained level
      '{CMD_TRAIN,    8'd10,  8'd20,  8'd30, -1},
      '{CMD_CLASSIFY, 8'd10,  8'd20,  8'd30,  1},
      '{CMD_CLASSIFY, 8'd11,  8'd20,  8'd30, -1},
      '{CMD_TRAIN,    8'd0,   8'd0,   8'd0,  -1},  // 0/0 saturates
      '{CMD_CLASSIFY, 8'd0,   8'd0,   8'd0,   1},
      '{CMD_TRAIN,    8'd255, 8'd1,   8'd255,-1},  // largest b/g ratio, below saturation
      '{CMD_CLASSIFY, 8'd255, 8'd1,   8'd255, 1},
      '{CMD_TRAIN,    8'd255, 8'd255, 8'd255,-1},
      '{CMD_CLASSIFY, 8'd255, 8'd255, 8'd255, 1},
      '{CMD_TRAIN,    8'd0,   8'd255, 8'd0,  -1},
      '{CMD_CLASSIFY, 8'd0,   8'd255, 8'd0,   1},
      '{CMD_TRAIN,    8'd200, 8'd100, 8'd50, -1},
      '{CMD_TRAIN,    8'd190, 8'd104, 8'd52, -1},
      '{CMD_CLASSIFY, 8'd195, 8'd102, 8'd51, -1},
      '{CMD_UNUSED,   8'd10,  8'd20,  8'd30, -1},  // unused cmd
      '{CMD_CLEAR,    8'd0,   8'd0,   8'd0,  -1},
      '{CMD_CLASSIFY, 8'd10,  8'd20,  8'd30,  0},
      '{CMD_CLASSIFY, 8'd255, 8'd255, 8'd255, 0}
   };

   task automatic random_pixel(output pixel_row row);
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 2)       row.cmd = CMD_CLEAR;
      else if (sel < 4)  row.cmd = CMD_UNUSED;
      else if (sel < 50) row.cmd = CMD_TRAIN;
      else               row.cmd = CMD_CLASSIFY;
      // mostly few pixel clusters so classify hits trained levels
      if ($urandom_range(0, 3) != 0) begin
         row.b = 8'($urandom_range(0, 3) * 60 + $urandom_range(0, 8));
         row.g = 8'($urandom_range(0, 3) * 60 + $urandom_range(0, 8));
         row.r = 8'($urandom_range(0, 3) * 60 + $urandom_range(0, 8));
      end else begin
         row.b = 8'($urandom); row.g = 8'($urandom); row.r = 8'($urandom);
      end
      row.want = -1;
   endtask

   initial begin
      pixel_row row;
      int burst;
      int gap;
      logic signed [8:0] margins [] = '{9'sd0, 9'sd128, -9'sd128, 9'sd5, -9'sd3,
                                         9'sh0FF, 9'sh100};
      foreach (level_trained[i]) level_trained[i] = 0;
      margin_val = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i]) send_pixel(directed[i]);

      foreach (margins[p]) begin
         write_margin(margins[p]);
         burst = 0;
         for (int n = 0; n < 165; n++) begin
            if (burst == 0) begin
               gap = $urandom_range(0, 6);
               if (gap > 0) begin
                  req_valid <= 1'b0;
                  repeat (gap) @(posedge clock);
               end
               burst = $urandom_range(1, 30);
            end
            burst--;
            random_pixel(row);
            send_pixel(row);
            if (p == 2 && n == 80) wait_drained();  // sender holds until caught up
         end
      end

      wait_drained();
      $display("Sent %0d pixels across %0d margin settings; %0d hits, %0d misses checked",
               transfers_in, margins.size(), hits_seen, misses_seen);
      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end
endmodule

// ----- color_ratio_table_segmenter.f -----
hw/rtl/crts_pkg.sv
hw/rtl/crts_ram.sv
hw/rtl/crts_divider.sv
hw/rtl/crts_front.sv
hw/rtl/crts_queue.sv
hw/rtl/crts_back.sv
hw/rtl/color_ratio_table_segmenter.sv
hw/rtl/crts_checker.sv
dv/color_ratio_table_segmenter_test.sv
